// File: rtl/next_greater_element_stream_assert.svh
// assertion macros used by the checker file
`ifndef NEXT_GREATER_ELEMENT_STREAM_ASSERT_SVH
`define NEXT_GREATER_ELEMENT_STREAM_ASSERT_SVH

// clocked assertion, held off while reset is high
`define NGES_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked assertion that also holds across reset
`define NGES_ASSERT_ALWAYS(name, clk, prop, msg) \
   name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/nges_pkg.sv
// shared constants and types of the next greater element stream
package nges_pkg;

   localparam int unsigned VALUE_W           = 32;
   localparam int unsigned STACK_DEPTH_DEF   = 32;

   typedef struct packed {
      logic                      last_of_run;
      logic                      overflow;
      logic                      has_greater;
      logic signed [VALUE_W-1:0] greater;
      logic signed [VALUE_W-1:0] element;
   } rsp_type;

endpackage

// File: rtl/next_greater_element_stream.sv
// Next greater element engine over a stream of signed 32-bit values. Each request is taken in,
// then pops the stored values smaller than it (one compare and pop per cycle against the
// cached stack top, while the output register is free), then is pushed or reported as an
// overflow; with the end mark set, the stack is then drained entry by entry. A new request
// is taken only once the last one is through. The stack sits in one ram with a registered
// read; the entry below the top is read ahead so a pop need not wait for the ram. Results
// leave through an output register and a stalled result holds the engine only when it must
// emit another.
module next_greater_element_stream
   import nges_pkg::*;
#(
   parameter int unsigned STACK_DEPTH = STACK_DEPTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [VALUE_W-1:0]     req_tdata,   // value
   input  logic                   req_tlast,   // end_of_sequence
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [2*VALUE_W-1:0]   rsp_tdata,   // element, greater
   output logic [1:0]             rsp_tuser,   // has_greater, overflow
   output logic                   rsp_tlast    // last_of_run
);

   localparam int unsigned AW = $clog2(STACK_DEPTH);
   localparam int unsigned CW = $clog2(STACK_DEPTH + 1);

   typedef enum logic [1:0] {IDLE, POP, FLUSH} state_type;

   state_type                 state_ff, state_in;
   logic [CW-1:0]             count_ff, count_in;
   logic signed [VALUE_W-1:0] top_ff, top_in;
   logic signed [VALUE_W-1:0] value_ff, value_in;
   logic                      eos_ff, eos_in;
   rsp_type                   rsp_ff, rsp_in;
   logic                      rsp_valid_ff, rsp_valid_in;

   logic               wr_en;
   logic [AW-1:0]      rd_addr;
   logic [VALUE_W-1:0] below;
   logic               out_free;
   logic               not_empty;
   logic               full;
   logic               top_less;
   logic               more_pop;
   logic               emit;
   rsp_type            rsp_new;

   nges_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (STACK_DEPTH)
   ) u_stack (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (AW'(count_ff)),
      .wr_data (value_ff),
      .rd_addr (rd_addr),
      .rd_data (below)
   );

   // read ahead the entry under the next top
   assign rd_addr = AW'(count_in - CW'(2));

   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign not_empty = count_ff != '0;
   assign full      = count_ff == CW'(STACK_DEPTH);
   assign top_less  = top_ff < value_ff;
   assign more_pop  = (count_ff > CW'(1)) && ($signed(below) < value_ff);

   assign req_tready = state_ff == IDLE;

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      top_in   = top_ff;
      value_in = value_ff;
      eos_in   = eos_ff;
      wr_en    = 1'b0;
      emit     = 1'b0;
      rsp_new  = '0;
      unique case (state_ff)
         IDLE: begin
            if (req_tvalid) begin
               value_in = req_tdata;
               eos_in   = req_tlast;
               state_in = POP;
            end
         end
         POP: begin
            priority if (not_empty && top_less) begin
               if (out_free) begin
                  emit                = 1'b1;
                  rsp_new.element     = top_ff;
                  rsp_new.greater     = value_ff;
                  rsp_new.has_greater = 1'b1;
                  rsp_new.last_of_run = !more_pop && !eos_ff;
                  count_in            = count_ff - CW'(1);
                  top_in              = $signed(below);
               end
            end else if (!full) begin
               wr_en    = 1'b1;
               top_in   = value_ff;
               count_in = count_ff + CW'(1);
               state_in = eos_ff ? FLUSH : IDLE;
            end else begin
               if (out_free) begin
                  emit                = 1'b1;
                  rsp_new.element     = value_ff;
                  rsp_new.overflow    = 1'b1;
                  rsp_new.last_of_run = !eos_ff;
                  state_in            = eos_ff ? FLUSH : IDLE;
               end
            end
         end
         FLUSH: begin
            if (out_free) begin
               emit                = 1'b1;
               rsp_new.element     = top_ff;
               rsp_new.last_of_run = count_ff == CW'(1);
               count_in            = count_ff - CW'(1);
               top_in              = $signed(below);
               if (count_ff == CW'(1)) begin
                  state_in = IDLE;
               end
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_in       = rsp_new;
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      top_ff   <= top_in;
      value_ff <= value_in;
      eos_ff   <= eos_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_ff.greater, rsp_ff.element};
   assign rsp_tuser  = {rsp_ff.overflow, rsp_ff.has_greater};
   assign rsp_tlast  = rsp_ff.last_of_run;

endmodule

// File: rtl/nges_ram.sv
// generic single write port ram with registered read
module nges_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// File: rtl/nges_checker.sv
// port level checks of the next greater element stream and their binding
`include "next_greater_element_stream_assert.svh"

module nges_checker
   import nges_pkg::*;
(
   input logic                 clock,
   input logic                 reset,
   input logic                 req_tvalid,
   input logic                 req_tready,
   input logic                 rsp_tvalid,
   input logic                 rsp_tready,
   input logic [2*VALUE_W-1:0] rsp_tdata,   // element, greater
   input logic [1:0]           rsp_tuser,   // has_greater, overflow
   input logic                 rsp_tlast    // last_of_run
);

   `NGES_ASSERT_ALWAYS(a_no_rsp_after_reset, clock,
      reset |=> !rsp_tvalid, "result valid after reset")
   `NGES_ASSERT(a_rsp_hold, clock, reset,
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser)
         && $stable(rsp_tlast), "stalled result changed")
   `NGES_ASSERT(a_overflow_no_pair, clock, reset,
      rsp_tvalid && rsp_tuser[1] |-> !rsp_tuser[0] && rsp_tdata[2*VALUE_W-1:VALUE_W] == '0,
      "overflow result carries a greater element")
   `NGES_ASSERT(a_none_zero, clock, reset,
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata[2*VALUE_W-1:VALUE_W] == '0,
      "result without greater element has nonzero greater")
   `NGES_ASSERT(a_one_request_at_once, clock, reset,
      req_tvalid && req_tready |=> !req_tready, "request taken while another is at work")

endmodule

bind next_greater_element_stream nges_checker u_checker (.*);

// File: tb/tb_next_greater_element_stream.sv
// self-checking testbench for the next greater element stream, with a monotonic stack predictor
module tb_next_greater_element_stream;
   import nges_pkg::*;

   localparam int unsigned DEPTH = STACK_DEPTH_DEF;
   localparam int DRILL_ROWS = 26;
   localparam int RANDOM_ITEMS = 140;
   localparam int SINK_HOLD_AT = 120;
   localparam int SINK_HOLD_CYCLES = 400;
   localparam int DRAIN_CYCLES = 80;
   localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;
   localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'sh7fff_ffff;

   typedef enum logic [1:0] {
      CHECK_PREDICTED,
      CHECK_NO_RESULT,
      CHECK_ONE_RESULT
   } row_check_type;

   typedef struct {
      logic [VALUE_W-1:0] value;
      logic               eos;
      int                 reps;
      row_check_type      check;
      rsp_type            answer;
   } drill_row_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [VALUE_W-1:0]   req_tdata = '0;      // value
   logic                 req_tlast = 1'b0;    // end_of_sequence
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [2*VALUE_W-1:0] rsp_tdata;           // element, greater
   logic [1:0]           rsp_tuser;           // has_greater, overflow
   logic                 rsp_tlast;           // last_of_run

   always #5 clock = ~clock;

   next_greater_element_stream #(
      .STACK_DEPTH(DEPTH)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tlast (req_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .rsp_tlast (rsp_tlast)
   );

   // values still waiting for a greater element, bottom first
   logic signed [VALUE_W-1:0] waiting_values [DEPTH];
   int unsigned               waiting_count = 0;
   rsp_type                   expected_answers [$];
   rsp_type                   fresh_answers [$];
   drill_row_type             drill_table [DRILL_ROWS];

   int mismatches = 0;
   int answers_seen = 0;
   int pairs_seen = 0;
   int drains_seen = 0;
   int overflows_seen = 0;
   int items_sent = 0;
   int widest_burst = 0;
   int source_idle_free = 0;
   int sink_idle_free = 0;

   function automatic rsp_type make_answer(input logic signed [VALUE_W-1:0] elem,
                                           input logic signed [VALUE_W-1:0] grt,
                                           input logic has, input logic ovf,
                                           input logic last);
      rsp_type a;
      a.element     = elem;
      a.greater     = grt;
      a.has_greater = has;
      a.overflow    = ovf;
      a.last_of_run = last;
      return a;
   endfunction

   function automatic void resolve_greater(input logic signed [VALUE_W-1:0] v,
                                           input logic eos);
      rsp_type tail;
      fresh_answers.delete();
      while (waiting_count > 0 && waiting_values[waiting_count-1] < v) begin
         waiting_count--;
         fresh_answers.insert(fresh_answers.size(),
                              make_answer(waiting_values[waiting_count], v,
                                          1'b1, 1'b0, 1'b0));
      end
      if (waiting_count < DEPTH) begin
         waiting_values[waiting_count] = v;
         waiting_count++;
      end else begin
         fresh_answers.insert(fresh_answers.size(), make_answer(v, '0, 1'b0, 1'b1, 1'b0));
      end
      if (eos) begin
         while (waiting_count > 0) begin
            waiting_count--;
            fresh_answers.insert(fresh_answers.size(),
                                 make_answer(waiting_values[waiting_count], '0,
                                             1'b0, 1'b0, 1'b0));
         end
      end
      if (fresh_answers.size() > 0) begin
         tail = fresh_answers.pop_back();
         tail.last_of_run = 1'b1;
         fresh_answers.insert(fresh_answers.size(), tail);
      end
      if (fresh_answers.size() > widest_burst) begin
         widest_burst = fresh_answers.size();
      end
   endfunction

   // random gap with occasional stretches of back-to-back traffic
   function automatic int draw_idle_cycles(inout int free_left);
      if (free_left > 0) begin
         free_left--;
         return 0;
      end
      if ($urandom_range(0, 15) == 0) begin
         free_left = $urandom_range(10, 30);
      end
      return $urandom_range(0, 14);
   endfunction

   function automatic logic [VALUE_W-1:0] draw_value();
      case ($urandom_range(0, 5))
         0, 1: return VALUE_W'(int'($urandom_range(0, 16)) - 8);
         2: return $urandom;
         3: begin
            case ($urandom_range(0, 3))
               0: return VAL_MIN;
               1: return VAL_MAX;
               2: return '0;
               default: return '1;
            endcase
         end
         default: return VALUE_W'(int'($urandom_range(0, 2000)) - 1000);
      endcase
   endfunction

   task automatic offer_value(input logic [VALUE_W-1:0] v, input logic eos,
                              input row_check_type check, input rsp_type answer);
      int gap;
      gap = draw_idle_cycles(source_idle_free);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= v;
      req_tlast  <= eos;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
      resolve_greater(v, eos);
      case (check)
         CHECK_PREDICTED: begin
            foreach (fresh_answers[i]) begin
               expected_answers.insert(expected_answers.size(), fresh_answers[i]);
            end
         end
         CHECK_ONE_RESULT: begin
            expected_answers.insert(expected_answers.size(), answer);
         end
         default: ;
      endcase
   endtask

   task automatic wait_for_quiet();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (expected_answers.size() != 0) @(posedge clock);
   endtask

   initial begin : stimulus
      int k;
      int run_len;
      int level;
      int shape;
      int random_sent;
      bit paused;
      drill_table = '{
         '{32'sd5,          1'b1, 1,  CHECK_ONE_RESULT,
           make_answer(32'sd5, '0, 1'b0, 1'b0, 1'b1)},
         '{VAL_MAX,         1'b1, 1,  CHECK_ONE_RESULT,
           make_answer(VAL_MAX, '0, 1'b0, 1'b0, 1'b1)},
         '{VAL_MIN,         1'b1, 1,  CHECK_ONE_RESULT,
           make_answer(VAL_MIN, '0, 1'b0, 1'b0, 1'b1)},
         '{32'sd0,          1'b0, 1,  CHECK_NO_RESULT,  '0},
         '{32'sd0,          1'b0, 1,  CHECK_PREDICTED,  '0},
         '{-32'sd1,         1'b0, 1,  CHECK_PREDICTED,  '0},
         '{32'sd1,          1'b0, 1,  CHECK_PREDICTED,  '0},
         '{VAL_MIN,         1'b0, 1,  CHECK_PREDICTED,  '0},
         '{VAL_MAX,         1'b0, 1,  CHECK_PREDICTED,  '0},
         '{32'sd3,          1'b1, 1,  CHECK_PREDICTED,  '0},
         '{32'sd10,         1'b0, 1,  CHECK_PREDICTED,  '0},
         '{32'sd9,          1'b0, 1,  CHECK_PREDICTED,  '0},
         '{32'sd8,          1'b0, 1,  CHECK_PREDICTED,  '0},
         '{32'sd7,          1'b1, 1,  CHECK_PREDICTED,  '0},
         '{32'sd1,          1'b0, 1,  CHECK_PREDICTED,  '0},
         '{32'sd2,          1'b0, 1,  CHECK_PREDICTED,  '0},
         '{32'sd3,          1'b0, 1,  CHECK_PREDICTED,  '0},
         '{32'sd4,          1'b0, 1,  CHECK_PREDICTED,  '0},
         '{32'sd100,        1'b1, 1,  CHECK_PREDICTED,  '0},
         '{32'sd7,          1'b0, 32, CHECK_PREDICTED,  '0},
         '{32'sd7,          1'b0, 1,  CHECK_ONE_RESULT,
           make_answer(32'sd7, '0, 1'b0, 1'b1, 1'b1)},
         '{VAL_MIN,         1'b1, 1,  CHECK_PREDICTED,  '0},
         '{32'sd4,          1'b0, 31, CHECK_PREDICTED,  '0},
         '{32'sd9,          1'b1, 1,  CHECK_PREDICTED,  '0},
         '{32'sh5555_5555,  1'b1, 1,  CHECK_ONE_RESULT,
           make_answer(32'sh5555_5555, '0, 1'b0, 1'b0, 1'b1)},
         '{32'shaaaa_aaaa,  1'b1, 1,  CHECK_ONE_RESULT,
           make_answer(32'shaaaa_aaaa, '0, 1'b0, 1'b0, 1'b1)}
      };
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (drill_table[i]) begin
         for (k = 0; k < drill_table[i].reps; k++) begin
            offer_value(drill_table[i].value, drill_table[i].eos, drill_table[i].check,
                        drill_table[i].answer);
         end
      end

      random_sent = 0;
      paused = 1'b0;
      while (random_sent < RANDOM_ITEMS) begin
         if (!paused && random_sent >= RANDOM_ITEMS / 2) begin
            paused = 1'b1;
            wait_for_quiet();
         end
         shape = $urandom_range(0, 9);
         if (shape < 7) begin
            // well-formed sequence with random content
            run_len = $urandom_range(1, 12);
            for (k = 0; k < run_len; k++) begin
               offer_value(draw_value(), k == run_len - 1, CHECK_PREDICTED, '0);
            end
         end else if (shape == 7) begin
            // long non-increasing run that can overflow the stack
            run_len = $urandom_range(30, 40);
            level = $urandom_range(0, 1000);
            for (k = 0; k < run_len; k++) begin
               offer_value(VALUE_W'(level), k == run_len - 1, CHECK_PREDICTED, '0);
               level -= $urandom_range(0, 2);
            end
         end else begin
            // noise with stray end marks
            run_len = $urandom_range(1, 8);
            for (k = 0; k < run_len; k++) begin
               offer_value(draw_value(), $urandom_range(0, 3) == 0, CHECK_PREDICTED, '0);
            end
         end
         random_sent += run_len;
      end

      wait_for_quiet();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("covered %0d requests and %0d responses: %0d pairs, %0d drained, %0d overflows",
               items_sent, answers_seen, pairs_seen, drains_seen, overflows_seen);
      $display("largest burst from one request: %0d responses, %0d mismatches",
               widest_burst, mismatches);
      if (mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   initial begin : answer_sink
      rsp_type want;
      rsp_type got;
      int      gap;
      bit      held;
      held = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         gap = draw_idle_cycles(sink_idle_free);
         if (!held && answers_seen >= SINK_HOLD_AT) begin
            held = 1'b1;
            gap = SINK_HOLD_CYCLES;
         end
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         got = {rsp_tlast, rsp_tuser[1], rsp_tuser[0],
                rsp_tdata[2*VALUE_W-1:VALUE_W], rsp_tdata[VALUE_W-1:0]};
         answers_seen++;
         if (got.overflow) begin
            overflows_seen++;
         end else if (got.has_greater) begin
            pairs_seen++;
         end else begin
            drains_seen++;
         end
         if (expected_answers.size() == 0) begin
            $display("%0t: unexpected response, expected none got element %0d greater %0d",
                     $time, got.element, got.greater);
            mismatches++;
         end else begin
            want = expected_answers.pop_front();
            if (got.element !== want.element) begin
               $display("%0t: element expected %0d got %0d", $time, want.element, got.element);
               mismatches++;
            end
            if (got.greater !== want.greater) begin
               $display("%0t: greater expected %0d got %0d", $time, want.greater, got.greater);
               mismatches++;
            end
            if (got.has_greater !== want.has_greater) begin
               $display("%0t: has_greater expected %0b got %0b", $time, want.has_greater,
                        got.has_greater);
               mismatches++;
            end
            if (got.overflow !== want.overflow) begin
               $display("%0t: overflow expected %0b got %0b", $time, want.overflow,
                        got.overflow);
               mismatches++;
            end
            if (got.last_of_run !== want.last_of_run) begin
               $display("%0t: last_of_run expected %0b got %0b", $time, want.last_of_run,
                        got.last_of_run);
               mismatches++;
            end
         end
      end
   end

   initial begin : watchdog
      #10_000_000;
      $display("%0t: timed out with %0d responses outstanding", $time, expected_answers.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

// File: files.f
+incdir+rtl
rtl/nges_pkg.sv
rtl/nges_ram.sv
rtl/next_greater_element_stream.sv
rtl/nges_checker.sv
tb/tb_next_greater_element_stream.sv
